/* hw/rtl/pair_co_occurrence_counter_defines.svh */
// assertion helpers for the pair co-occurrence counter
`ifndef PAIR_CO_OCCURRENCE_COUNTER_DEFINES_SVH
`define PAIR_CO_OCCURRENCE_COUNTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/pcc_pkg.sv */
`default_nettype none
package pcc_pkg;

  localparam int PATTERN_COUNT = 16;
  localparam int PATTERN_BITS  = 4;
  localparam int COUNT_BITS    = 16;
  localparam int PAIR_SLOTS    = (PATTERN_COUNT * (PATTERN_COUNT - 1)) / 2;
  localparam int SLOT_BITS     = $clog2(PAIR_SLOTS);
  localparam int STAMP_BITS    = 32;
  localparam int WINDOW_BITS   = 31;
  localparam int WIDE          = 96;
  localparam int MUL_BITS      = 32;
  localparam int QUO_BITS      = 24;
  localparam int STEP_BITS     = 5;

  localparam logic CFG_WINDOW    = 1'b0;
  localparam logic CFG_MIN_PAIRS = 1'b1;

  typedef enum logic [1:0] {
    K_SINGLE = 2'd0,
    K_BATCH  = 2'd1,
    K_QUERY  = 2'd2,
    K_CLEAR  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [PATTERN_BITS-1:0] pattern;
    logic [PATTERN_BITS-1:0] other_pattern;
    logic [STAMP_BITS-1:0]   stamp;
    logic                    batch_end;
  } item_t;

  typedef struct packed {
    logic [15:0] pair_count;
    logic [16:0] probability;
    logic [23:0] chi_stat;
    logic        significant;
  } result_t;

  typedef struct packed {
    logic [STAMP_BITS-1:0]   stamp;
    logic [PATTERN_BITS-1:0] pat;
  } hist_entry_t;

  typedef enum logic {
    MD_MUL = 1'b0,
    MD_DIV = 1'b1
  } md_op_t;

  typedef struct packed {
    logic                 start;
    md_op_t               op;
    logic [STEP_BITS-1:0] steps;
  } md_req_t;

  typedef struct packed {
    logic            done;
    logic [WIDE-1:0] result;
  } md_rsp_t;

endpackage
`default_nettype wire

/* hw/rtl/pair_co_occurrence_counter.sv */
// Pair co-occurrence counter. Every item yields exactly one result; only a pair
// query carries non-zero fields. Items are handled one at a time by a sequencer
// around a history RAM with one read port, a pair-count RAM and one shared shift-add
// multiply / restoring divide unit, so item_stall stays high until the item's
// work is done. A clear and a batch element without batch_end go straight to
// the finish. A single activation scans the history, sweeps the pairs (one read
// and one write per bumped pair) and prunes old entries; the batch-closing
// element sweeps the pairs only. A query reads and combines the counts, runs
// up to nine shift-add multiplies, the 24-step chi-squared divide and the
// 16-step probability divide, then finishes.
// There is no clearing pass after reset or clear.
`default_nettype none
`include "pair_co_occurrence_counter_defines.svh"
module pair_co_occurrence_counter import pcc_pkg::*; #(
  parameter int HISTORY_DEPTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output      logic                   item_stall,
  input  wire item_t                  item,
  output      logic                   result_valid,
  input  wire logic                   result_stall,
  output      result_t                result,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic                   cfg_index,
  input  wire logic [WINDOW_BITS-1:0] cfg_data
);

  localparam int HAW = $clog2(HISTORY_DEPTH);
  localparam int FW  = $clog2(HISTORY_DEPTH + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN, S_PAIR, S_PAIR_WR, S_PRUNE_RD, S_PRUNE_CHK,
    S_Q_RD, S_Q_A, S_Q_BC, S_Q_D, S_Q_SUMS, S_Q_OP, S_Q_WAIT, S_Q_SAT,
    S_Q_PROB, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    QS_AD, QS_BC, QS_SQ, QS_NUM, QS_D1, QS_D2, QS_D3, QS_LHS, QS_RHS,
    QS_CHI, QS_PROB
  } qstep_t;

  function automatic logic [SLOT_BITS-1:0] pair_slot(input logic [PATTERN_BITS-1:0] p,
                                                     input logic [PATTERN_BITS-1:0] q);
    logic [PATTERN_BITS-1:0] lo;
    logic [PATTERN_BITS-1:0] hi;
    logic [15:0]             base;
    lo   = (p < q) ? p : q;
    hi   = (p < q) ? q : p;
    base = (16'(lo) * (16'(2 * PATTERN_COUNT - 1) - 16'(lo))) >> 1;
    return SLOT_BITS'(base + 16'(hi) - 16'(lo) - 16'd1);
  endfunction

  function automatic logic [HAW-1:0] wrap_add(input logic [HAW-1:0] base,
                                              input logic [HAW-1:0] off);
    logic [HAW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (HAW+1)'(HISTORY_DEPTH)) begin
      s = s - (HAW+1)'(HISTORY_DEPTH);
    end
    return s[HAW-1:0];
  endfunction

  state_t                  state;
  qstep_t                  qstep;
  item_t                   cur;
  logic [WINDOW_BITS-1:0]  window_length;
  logic [15:0]             min_pair_count;
  logic [HAW-1:0]          head;
  logic [FW-1:0]           fill;
  logic [COUNT_BITS-1:0]   single_counts [PATTERN_COUNT];
  logic [PAIR_SLOTS-1:0]   pair_valid;
  logic [COUNT_BITS-1:0]   batch_total;
  logic [PATTERN_COUNT-1:0] batch_members;
  logic [PATTERN_COUNT-1:0] mask;
  logic [STAMP_BITS-1:0]   win_start;
  logic [STAMP_BITS-1:0]   cutoff;
  logic [FW-1:0]           scan_i;
  logic                    scan_pend;
  logic [PATTERN_BITS-1:0] pi;
  logic [PATTERN_BITS-1:0] pj;
  logic [SLOT_BITS-1:0]    slot;
  logic [COUNT_BITS-1:0]   c1, c2, qa, qb, qc, qd;
  logic [COUNT_BITS:0]     ab, cd, ac, bd;
  logic [31:0]             ad;
  logic [31:0]             diff;
  logic [WIDE-1:0]         work;
  logic [WIDE-1:0]         num;
  logic [WIDE-1:0]         den;
  logic                    above;
  logic [23:0]             chi;
  logic [16:0]             prob;
  logic                    is_query;

  logic                    hist_we;
  logic [HAW-1:0]          hist_waddr;
  logic [HAW-1:0]          hist_raddr;
  hist_entry_t             hist_wdata;
  hist_entry_t             hist_rdata;
  logic                    pair_we;
  logic [SLOT_BITS-1:0]    pair_raddr;
  logic [COUNT_BITS-1:0]   pair_wdata;
  logic [COUNT_BITS-1:0]   pair_rdata;
  logic [COUNT_BITS-1:0]   pair_cur;
  md_req_t                 md_req;
  md_rsp_t                 md_rsp;
  logic [WIDE-1:0]         md_x;
  logic [WIDE-1:0]         md_y;

  logic                    accept;
  logic                    hist_full;
  logic                    pair_last;
  logic                    pair_hit;
  logic [COUNT_BITS+1:0]   used;
  logic [STAMP_BITS-1:0]   span;
  logic [SLOT_BITS-1:0]    qslot;

  assign accept    = item_valid && !item_stall;
  assign item_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign hist_full = (fill == FW'(HISTORY_DEPTH));
  assign span      = {window_length, 1'b0};
  assign qslot     = pair_slot(cur.pattern, cur.other_pattern);
  assign pair_hit  = mask[pi] && mask[pj];
  assign pair_last = (pi == PATTERN_BITS'(PATTERN_COUNT - 2)) &&
                     (pj == PATTERN_BITS'(PATTERN_COUNT - 1));
  assign pair_cur  = pair_valid[slot] ? pair_rdata : '0;
  assign used      = (COUNT_BITS+2)'(qa) + (COUNT_BITS+2)'(qb) + (COUNT_BITS+2)'(qc);

  // history write happens only on the append cycle
  assign hist_we          = accept && (item.kind == K_SINGLE || item.kind == K_BATCH);
  assign hist_waddr       = hist_full ? head : wrap_add(head, fill[HAW-1:0]);
  assign hist_wdata.stamp = item.stamp;
  assign hist_wdata.pat   = item.pattern;
  assign hist_raddr       = (state == S_SCAN) ? wrap_add(head, scan_i[HAW-1:0]) : head;

  assign pair_we    = (state == S_PAIR_WR);
  assign pair_raddr = (state == S_Q_RD) ? qslot : slot;
  assign pair_wdata = (pair_cur == CMAX) ? CMAX : pair_cur + COUNT_BITS'(1);

  pcc_ram #(.WIDTH($bits(hist_entry_t)), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  pcc_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAIR_SLOTS)) u_pairs (
    .clk   (clk),
    .we    (pair_we),
    .waddr (slot),
    .wdata (pair_wdata),
    .raddr (pair_raddr),
    .rdata (pair_rdata)
  );

  pcc_muldiv u_md (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .x   (md_x),
    .y   (md_y),
    .rsp (md_rsp)
  );

  always_comb begin
    md_req.start = (state == S_Q_OP);
    md_req.op    = MD_MUL;
    md_req.steps = '0;
    md_x         = '0;
    md_y         = '0;
    unique case (qstep)
      QS_AD:   begin md_x = WIDE'(qa);   md_y = WIDE'(qd);     end
      QS_BC:   begin md_x = WIDE'(qb);   md_y = WIDE'(qc);     end
      QS_SQ:   begin md_x = WIDE'(diff); md_y = WIDE'(diff);   end
      QS_NUM:  begin md_x = work;        md_y = WIDE'(batch_total); end
      QS_D1:   begin md_x = WIDE'(ab);   md_y = WIDE'(cd);     end
      QS_D2:   begin md_x = work;        md_y = WIDE'(ac);     end
      QS_D3:   begin md_x = work;        md_y = WIDE'(bd);     end
      QS_LHS:  begin md_x = num;         md_y = WIDE'(1000);   end
      QS_RHS:  begin md_x = den;         md_y = WIDE'(3841);   end
      QS_CHI: begin
        md_req.op    = MD_DIV;
        md_req.steps = STEP_BITS'(24);
        md_x         = num << 8;
        md_y         = den << 23;
      end
      QS_PROB: begin
        md_req.op    = MD_DIV;
        md_req.steps = STEP_BITS'(16);
        md_x         = WIDE'(qa) << 16;
        md_y         = WIDE'(batch_total) << 15;
      end
      default: begin md_x = '0; md_y = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      qstep          <= QS_AD;
      window_length  <= WINDOW_BITS'(100);
      min_pair_count <= 16'd3;
      head           <= '0;
      fill           <= '0;
      pair_valid     <= '0;
      batch_total    <= '0;
      batch_members  <= '0;
      result_valid   <= 1'b0;
      for (int k = 0; k < PATTERN_COUNT; k++) begin
        single_counts[k] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_WINDOW:    window_length  <= cfg_data;
          CFG_MIN_PAIRS: min_pair_count <= cfg_data[15:0];
          default:       ;
        endcase
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur      <= item;
            is_query <= (item.kind == K_QUERY);
            unique case (item.kind)
              K_SINGLE, K_BATCH: begin
                if (hist_full) begin
                  head <= (head == HAW'(HISTORY_DEPTH - 1)) ? '0 : head + HAW'(1);
                end else begin
                  fill <= fill + FW'(1);
                end
                if (single_counts[item.pattern] != CMAX) begin
                  single_counts[item.pattern] <= single_counts[item.pattern] + COUNT_BITS'(1);
                end
                pi   <= '0;
                pj   <= PATTERN_BITS'(1);
                slot <= '0;
                if (item.kind == K_SINGLE) begin
                  win_start <= (item.stamp > STAMP_BITS'(window_length))
                             ? item.stamp - STAMP_BITS'(window_length) : '0;
                  cutoff    <= (item.stamp > span) ? item.stamp - span : '0;
                  mask      <= '0;
                  scan_i    <= '0;
                  scan_pend <= 1'b0;
                  state     <= S_SCAN;
                end else if (item.batch_end) begin
                  mask          <= batch_members | (PATTERN_COUNT'(1) << item.pattern);
                  batch_members <= '0;
                  batch_total   <= (batch_total == CMAX) ? CMAX : batch_total + COUNT_BITS'(1);
                  state         <= S_PAIR;
                end else begin
                  batch_members <= batch_members | (PATTERN_COUNT'(1) << item.pattern);
                  state         <= S_FIN;
                end
              end
              K_QUERY: begin
                state <= S_Q_RD;
              end
              K_CLEAR: begin
                head          <= '0;
                fill          <= '0;
                pair_valid    <= '0;
                batch_total   <= '0;
                batch_members <= '0;
                for (int k = 0; k < PATTERN_COUNT; k++) begin
                  single_counts[k] <= '0;
                end
                state <= S_FIN;
              end
              default: state <= S_FIN;
            endcase
          end
        end

        // read data are compared in the cycle after their address is set
        S_SCAN: begin
          scan_pend <= (scan_i < fill);
          if (scan_i < fill) begin
            scan_i <= scan_i + FW'(1);
          end
          if (scan_pend && hist_rdata.stamp >= win_start && hist_rdata.stamp <= cur.stamp) begin
            mask[hist_rdata.pat] <= 1'b1;
          end
          if (!(scan_i < fill) && !scan_pend) begin
            state <= S_PAIR;
          end
        end

        S_PAIR, S_PAIR_WR: begin
          if (state == S_PAIR && pair_hit) begin
            state <= S_PAIR_WR;
          end else begin
            if (state == S_PAIR_WR) begin
              pair_valid[slot] <= 1'b1;
            end
            slot <= slot + SLOT_BITS'(1);
            if (pair_last) begin
              state <= (cur.kind == K_SINGLE) ? S_PRUNE_RD : S_FIN;
            end else begin
              state <= S_PAIR;
              if (pj == PATTERN_BITS'(PATTERN_COUNT - 1)) begin
                pi <= pi + PATTERN_BITS'(1);
                pj <= pi + PATTERN_BITS'(2);
              end else begin
                pj <= pj + PATTERN_BITS'(1);
              end
            end
          end
        end

        S_PRUNE_RD: begin
          state <= (fill == '0) ? S_FIN : S_PRUNE_CHK;
        end

        S_PRUNE_CHK: begin
          if (hist_rdata.stamp < cutoff) begin
            head  <= (head == HAW'(HISTORY_DEPTH - 1)) ? '0 : head + HAW'(1);
            fill  <= fill - FW'(1);
            state <= S_PRUNE_RD;
          end else begin
            state <= S_FIN;
          end
        end

        S_Q_RD: begin
          c1    <= single_counts[cur.pattern];
          state <= S_Q_A;
        end

        S_Q_A: begin
          qa    <= (cur.pattern != cur.other_pattern && pair_valid[qslot]) ? pair_rdata : '0;
          c2    <= single_counts[cur.other_pattern];
          state <= S_Q_BC;
        end

        S_Q_BC: begin
          qb    <= (c1 > qa) ? c1 - qa : '0;
          qc    <= (c2 > qa) ? c2 - qa : '0;
          state <= S_Q_D;
        end

        S_Q_D: begin
          qd    <= ((COUNT_BITS+2)'(batch_total) > used)
                 ? batch_total - used[COUNT_BITS-1:0] : '0;
          ab    <= (COUNT_BITS+1)'(qa) + (COUNT_BITS+1)'(qb);
          ac    <= (COUNT_BITS+1)'(qa) + (COUNT_BITS+1)'(qc);
          state <= S_Q_SUMS;
        end

        S_Q_SUMS: begin
          cd <= (COUNT_BITS+1)'(qc) + (COUNT_BITS+1)'(qd);
          bd <= (COUNT_BITS+1)'(qb) + (COUNT_BITS+1)'(qd);
          // any empty margin makes the statistic zero
          if (batch_total == '0 || c1 == '0 || c2 == '0 || ab == '0 || ac == '0 ||
              (qc == '0 && qd == '0) || (qb == '0 && qd == '0)) begin
            chi   <= '0;
            above <= 1'b0;
            state <= S_Q_PROB;
          end else begin
            qstep <= QS_AD;
            state <= S_Q_OP;
          end
        end

        S_Q_OP: begin
          state <= S_Q_WAIT;
        end

        S_Q_WAIT: begin
          if (md_rsp.done) begin
            state <= S_Q_OP;
            unique case (qstep)
              QS_AD: begin
                ad    <= md_rsp.result[31:0];
                qstep <= QS_BC;
              end
              QS_BC: begin
                diff  <= (ad > md_rsp.result[31:0]) ? ad - md_rsp.result[31:0]
                                                    : md_rsp.result[31:0] - ad;
                qstep <= QS_SQ;
              end
              QS_SQ:  begin work <= md_rsp.result; qstep <= QS_NUM; end
              QS_NUM: begin num  <= md_rsp.result; qstep <= QS_D1;  end
              QS_D1:  begin work <= md_rsp.result; qstep <= QS_D2;  end
              QS_D2:  begin work <= md_rsp.result; qstep <= QS_D3;  end
              QS_D3:  begin den  <= md_rsp.result; qstep <= QS_LHS; end
              QS_LHS: begin work <= md_rsp.result; qstep <= QS_RHS; end
              QS_RHS: begin
                above <= (work > md_rsp.result);
                state <= S_Q_SAT;
              end
              QS_CHI: begin
                chi   <= md_rsp.result[23:0];
                state <= S_Q_PROB;
              end
              QS_PROB: begin
                prob  <= md_rsp.result[16:0];
                state <= S_FIN;
              end
              default: state <= S_FIN;
            endcase
          end
        end

        S_Q_SAT: begin
          if (num >= (den << 16)) begin
            chi   <= '1;
            state <= S_Q_PROB;
          end else begin
            qstep <= QS_CHI;
            state <= S_Q_OP;
          end
        end

        S_Q_PROB: begin
          if (qa == '0 || batch_total == '0) begin
            prob  <= '0;
            state <= S_FIN;
          end else if (qa >= batch_total) begin
            prob  <= 17'h10000;
            state <= S_FIN;
          end else begin
            qstep <= QS_PROB;
            state <= S_Q_OP;
          end
        end

        S_FIN: begin
          if (!result_valid || !result_stall) begin
            result_valid       <= 1'b1;
            result.pair_count  <= is_query ? qa : '0;
            result.probability <= is_query ? prob : '0;
            result.chi_stat    <= is_query ? chi : '0;
            result.significant <= is_query && (qa >= min_pair_count) && above;
            state              <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `PCC_ASSERT_NEXT(a_clear_empties, accept && item.kind == K_CLEAR, fill == '0 && batch_total == '0 && pair_valid == '0, "clear left state behind")
  `PCC_ASSERT_NOW(a_md_done_waited, md_rsp.done, state == S_Q_WAIT, "arith unit finished outside a wait")
  `PCC_ASSERT_NOW(a_result_from_fin, $rose(result_valid), $past(state == S_FIN), "result raised outside finish")

endmodule
`default_nettype wire

/* hw/rtl/pcc_ram.sv */
`default_nettype none
module pcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/pcc_muldiv.sv */
`default_nettype none
module pcc_muldiv import pcc_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire md_req_t         req,
  input  wire logic [WIDE-1:0] x,
  input  wire logic [WIDE-1:0] y,
  output      md_rsp_t         rsp
);

  logic                 busy;
  logic                 done;
  md_op_t               op;
  logic [WIDE-1:0]      acc;
  logic [WIDE-1:0]      opd;
  logic [MUL_BITS-1:0]  mp;
  logic [QUO_BITS-1:0]  quo;
  logic [STEP_BITS-1:0] cnt;
  logic [WIDE:0]        sum;

  // one shared adder: add for multiply, subtract-and-compare for divide
  assign sum = (op == MD_MUL) ? {1'b0, acc} + {1'b0, opd}
                              : {1'b0, acc} + {1'b0, ~opd} + (WIDE+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        if (req.op == MD_MUL) begin
          acc <= '0;
          opd <= x;
          mp  <= y[MUL_BITS-1:0];
        end else begin
          acc <= x;
          opd <= y;
          quo <= '0;
          cnt <= req.steps;
        end
      end else if (busy) begin
        if (op == MD_MUL) begin
          if (mp == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            if (mp[0]) begin
              acc <= sum[WIDE-1:0];
            end
            opd <= opd << 1;
            mp  <= mp >> 1;
          end
        end else begin
          if (cnt == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            // carry out means remainder >= shifted divisor
            if (sum[WIDE]) begin
              acc <= sum[WIDE-1:0];
            end
            quo <= {quo[QUO_BITS-2:0], sum[WIDE]};
            opd <= opd >> 1;
            cnt <= cnt - STEP_BITS'(1);
          end
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = (op == MD_MUL) ? acc : WIDE'(quo);

endmodule
`default_nettype wire

/* tb/pair_co_occurrence_counter_tb.sv */
`default_nettype none
module pair_co_occurrence_counter_tb;
  import pcc_pkg::*;

  localparam int DEPTH = 64;
  localparam int NPAT = 16;
  localparam longint unsigned CNT_MAX = 65535;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 700;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  item_t item;
  logic result_valid;
  logic result_stall;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [WINDOW_BITS-1:0] cfg_data;

  pair_co_occurrence_counter dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  longint unsigned win_len;
  longint unsigned min_pairs;
  bit [31:0] hist_stamp [DEPTH];
  bit [3:0] hist_pat [DEPTH];
  int hist_head;
  int hist_fill;
  longint unsigned pat_cnt [NPAT];
  longint unsigned pair_cnt [NPAT][NPAT];
  longint unsigned batches;
  bit [NPAT-1:0] open_batch;

  item_t pending_requests[$];
  result_t expected_results[$];
  int mismatches;
  int results_seen;
  int quiet_cycles;
  bit quiet_mode;

  function automatic longint unsigned sat_inc(longint unsigned v);
    return (v < CNT_MAX) ? v + 1 : CNT_MAX;
  endfunction

  function automatic void wipe_counts();
    hist_head = 0;
    hist_fill = 0;
    for (int i = 0; i < NPAT; i++) begin
      pat_cnt[i] = 0;
      for (int j = 0; j < NPAT; j++) pair_cnt[i][j] = 0;
    end
    batches = 0;
    open_batch = '0;
  endfunction

  function automatic void log_activation(bit [3:0] p, bit [31:0] s);
    int slot;
    if (hist_fill >= DEPTH) begin
      slot = hist_head;
      hist_head = (hist_head + 1) % DEPTH;
    end else begin
      slot = (hist_head + hist_fill) % DEPTH;
      hist_fill++;
    end
    hist_stamp[slot] = s;
    hist_pat[slot] = p;
    pat_cnt[p] = sat_inc(pat_cnt[p]);
  endfunction

  function automatic void bump_group(bit [NPAT-1:0] m);
    for (int i = 0; i < NPAT; i++)
      for (int j = i + 1; j < NPAT; j++)
        if (m[i] && m[j]) pair_cnt[i][j] = sat_inc(pair_cnt[i][j]);
  endfunction

  function automatic bit [23:0] chi_fixed(int p, int q, longint unsigned a, output bit above);
    longint unsigned n, b, c, d, used, ad, bc, diff;
    bit [191:0] num, den, scaled;
    above = 0;
    n = batches;
    if (n == 0 || pat_cnt[p] == 0 || pat_cnt[q] == 0) return '0;
    b = (pat_cnt[p] > a) ? pat_cnt[p] - a : 0;
    c = (pat_cnt[q] > a) ? pat_cnt[q] - a : 0;
    used = a + b + c;
    d = (n > used) ? n - used : 0;
    if (a + b == 0 || c + d == 0 || a + c == 0 || b + d == 0) return '0;
    ad = a * d;
    bc = b * c;
    diff = (ad > bc) ? ad - bc : bc - ad;
    den = 192'(a + b);
    den = den * 192'(c + d);
    den = den * 192'(a + c);
    den = den * 192'(b + d);
    num = 192'(diff);
    num = num * 192'(diff);
    num = num * 192'(n);
    above = (num * 192'd1000) > (den * 192'd3841);
    scaled = num * 192'd256;
    if (scaled >= (den << 24)) return 24'hFFFFFF;
    return 24'(scaled / den);
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t r;
    longint unsigned lo_edge, cutoff, span, a, prob;
    bit [NPAT-1:0] seen;
    bit above;
    int s;
    r = '0;
    case (it.kind)
      K_SINGLE: begin
        lo_edge = (it.stamp > win_len) ? it.stamp - win_len : 0;
        span = 2 * win_len;
        cutoff = (it.stamp > span) ? it.stamp - span : 0;
        log_activation(it.pattern, it.stamp);
        seen = '0;
        for (int i = 0; i < hist_fill; i++) begin
          s = (hist_head + i) % DEPTH;
          if (hist_stamp[s] >= lo_edge && hist_stamp[s] <= it.stamp) seen[hist_pat[s]] = 1;
        end
        bump_group(seen);
        while (hist_fill > 0 && hist_stamp[hist_head] < cutoff) begin
          hist_head = (hist_head + 1) % DEPTH;
          hist_fill--;
        end
      end
      K_BATCH: begin
        log_activation(it.pattern, it.stamp);
        open_batch[it.pattern] = 1;
        if (it.batch_end) begin
          bump_group(open_batch);
          batches = sat_inc(batches);
          open_batch = '0;
        end
      end
      K_QUERY: begin
        if (it.pattern == it.other_pattern) a = 0;
        else if (it.pattern < it.other_pattern) a = pair_cnt[it.pattern][it.other_pattern];
        else a = pair_cnt[it.other_pattern][it.pattern];
        r.chi_stat = chi_fixed(it.pattern, it.other_pattern, a, above);
        prob = 0;
        if (a != 0 && batches != 0) begin
          prob = (a << 16) / batches;
          if (prob > 65536) prob = 65536;
        end
        r.pair_count = 16'(a);
        r.probability = 17'(prob);
        r.significant = (a >= min_pairs) && above;
      end
      default: wipe_counts();
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // request driver
  int send_gap;
  always @(posedge clk) begin
    bit next_valid;
    if (rst) begin
      item_valid <= 0;
      item <= '0;
      send_gap = 0;
    end else begin
      next_valid = item_valid;
      if (item_valid && !item_stall) begin
        expected_results.insert(expected_results.size(), predict_result(item));
        next_valid = 0;
        send_gap = quiet_mode ? 0 : $urandom_range(0, 14);
      end
      if (!next_valid) begin
        if (send_gap > 0) send_gap = send_gap - 1;
        else if (pending_requests.size() > 0) begin
          item <= pending_requests[0];
          pending_requests.delete(0);
          next_valid = 1;
        end
      end
      item_valid <= next_valid;
    end
  end

  // result monitor, with one long hold-off to back the block up
  int recv_wait;
  int hold_left;
  bit hold_done;
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_stall <= 0;
      recv_wait = 0;
      hold_left = 0;
      hold_done = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", result, 0);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (result.pair_count !== want.pair_count)
            report_mismatch("pair_count", result.pair_count, want.pair_count);
          if (result.probability !== want.probability)
            report_mismatch("probability", result.probability, want.probability);
          if (result.chi_stat !== want.chi_stat)
            report_mismatch("chi_stat", result.chi_stat, want.chi_stat);
          if (result.significant !== want.significant)
            report_mismatch("significant", result.significant, want.significant);
        end
        results_seen++;
        recv_wait = quiet_mode ? 0 : $urandom_range(0, 14);
        if (results_seen == 300 && !hold_done) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        result_stall <= 1;
      end else begin
        result_stall <= 0;
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no progress in %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_reg(logic idx, bit [30:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == CFG_WINDOW) win_len = val;
    else min_pairs = val[15:0];
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_requests.size() != 0 || item_valid || expected_results.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic item_t make_item(kind_t k, int p, int q, bit [31:0] s, bit e);
    item_t it;
    it.kind = k;
    it.pattern = 4'(p);
    it.other_pattern = 4'(q);
    it.stamp = s;
    it.batch_end = e;
    return it;
  endfunction

  task automatic add_request(item_t it);
    pending_requests.insert(pending_requests.size(), it);
  endtask

  bit [31:0] clock_now;

  task automatic queue_random(int count);
    item_t it;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 59) == 0) clock_now = $urandom;
      else clock_now = clock_now + $urandom_range(0, 25);
      it.stamp = clock_now;
      // occasional step back in time
      if ($urandom_range(0, 29) == 0) it.stamp = clock_now - $urandom_range(0, 300);
      it.kind = (r < 38) ? K_SINGLE : (r < 70) ? K_BATCH : (r < 98) ? K_QUERY : K_CLEAR;
      it.pattern = $urandom_range(0, 1) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(0, 15));
      it.other_pattern = $urandom_range(0, 1) ? 4'($urandom_range(0, 4))
                                              : 4'($urandom_range(0, 15));
      it.batch_end = (it.kind == K_BATCH) ? ($urandom_range(0, 3) == 0) : 1'($urandom);
      add_request(it);
    end
  endtask

  initial begin
    rst = 1;
    cfg_valid = 0;
    cfg_index = CFG_WINDOW;
    cfg_data = '0;
    mismatches = 0;
    results_seen = 0;
    quiet_mode = 0;
    win_len = 100;
    min_pairs = 3;
    clock_now = 0;
    wipe_counts();
    repeat (11) @(posedge clk);
    rst <= 0;

    // directed: early stamps, edge patterns, batches, queries, clear
    add_request(make_item(K_SINGLE, 0, 0, 32'd0, 1'b1));
    add_request(make_item(K_SINGLE, 15, 3, 32'd5, 1'b0));
    add_request(make_item(K_SINGLE, 7, 0, 32'd50, 1'b0));
    add_request(make_item(K_BATCH, 0, 0, 32'd60, 1'b0));
    add_request(make_item(K_BATCH, 15, 0, 32'd61, 1'b0));
    add_request(make_item(K_SINGLE, 3, 0, 32'd62, 1'b0));
    add_request(make_item(K_BATCH, 7, 0, 32'd63, 1'b1));
    add_request(make_item(K_BATCH, 0, 15, 32'd64, 1'b1));
    add_request(make_item(K_QUERY, 0, 15, 32'd64, 1'b0));
    add_request(make_item(K_QUERY, 15, 0, 32'd64, 1'b1));
    add_request(make_item(K_QUERY, 7, 7, 32'd64, 1'b0));
    add_request(make_item(K_SINGLE, 2, 0, 32'd40, 1'b0));
    add_request(make_item(K_SINGLE, 9, 0, 32'd500, 1'b0));
    add_request(make_item(K_SINGLE, 10, 0, 32'hFFFF_FFFF, 1'b1));
    add_request(make_item(K_QUERY, 0, 7, 32'hFFFF_FFFF, 1'b0));
    add_request(make_item(K_BATCH, 4, 0, 32'hFFFF_FFFF, 1'b1));
    add_request(make_item(K_QUERY, 4, 15, 32'hFFFF_FFFF, 1'b0));
    add_request(make_item(K_CLEAR, 15, 15, 32'hFFFF_FFFF, 1'b1));
    add_request(make_item(K_QUERY, 0, 15, 32'd0, 1'b0));
    add_request(make_item(K_SINGLE, 1, 0, 32'd0, 1'b0));
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(CFG_WINDOW, 31'd100); write_reg(CFG_MIN_PAIRS, 31'd3); end
        1: begin write_reg(CFG_WINDOW, 31'd0); write_reg(CFG_MIN_PAIRS, 31'd0); end
        2: begin write_reg(CFG_WINDOW, 31'h7FFF_FFFF); write_reg(CFG_MIN_PAIRS, 31'hFFFF); end
        3: begin write_reg(CFG_WINDOW, 31'd7); write_reg(CFG_MIN_PAIRS, 31'd1); end
        4: begin
          write_reg(CFG_WINDOW, 31'($urandom_range(1, 400)));
          write_reg(CFG_MIN_PAIRS, 31'($urandom_range(0, 8)));
        end
        default: begin
          write_reg(CFG_WINDOW, 31'($urandom));
          write_reg(CFG_MIN_PAIRS, 31'($urandom));
        end
      endcase
      quiet_mode = (phase == 3);
      queue_random(305);
      wait_idle();
    end

    repeat (500) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
+incdir+hw/rtl
hw/rtl/pcc_pkg.sv
hw/rtl/pcc_ram.sv
hw/rtl/pcc_muldiv.sv
hw/rtl/pair_co_occurrence_counter.sv
tb/pair_co_occurrence_counter_tb.sv
